// ===== sv/piecewise_offset_remap_table_assert.svh =====
// Assertion macros used by the checker of the offset remap table.
`ifndef PIECEWISE_OFFSET_REMAP_TABLE_ASSERT_SVH
`define PIECEWISE_OFFSET_REMAP_TABLE_ASSERT_SVH

// Property holds at every edge outside reset.
`define PORM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("porm check failed");

// Antecedent at one edge requires the consequent at the next.
`define PORM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("porm check failed");

`endif

// ===== sv/porm_pkg.sv =====
// Shared opcodes and cell command type for the offset remap table.
package porm_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_SET   = 3'd1,
    OP_FWD   = 3'd2,
    OP_REV   = 3'd3,
    OP_DELTA = 3'd4
  } op_e;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clr;    // drop all entries
    logic upd;    // overwrite value of the matching key
    logic ins;    // insert at the sorted position, shift the rest up
    logic probe;  // leaf flag reports key equality
    logic rev;    // look up on the value column
  } cell_cmd_t;

endpackage

// ===== sv/porm_cell.sv =====
// One table entry: anchor storage, compares and the shift hand-off to the next cell.
module porm_cell #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  porm_pkg::cell_cmd_t   cmd_i,
  input  logic [POS_WIDTH-1:0]  query_i,
  input  logic [POS_WIDTH-1:0]  data_i,
  input  logic [POS_WIDTH-1:0]  prev_key_i,
  input  logic [POS_WIDTH-1:0]  prev_val_i,
  input  logic                  prev_vld_i,
  input  logic                  prev_lt_i,
  output logic [POS_WIDTH-1:0]  key_o,
  output logic [POS_WIDTH-1:0]  val_o,
  output logic                  vld_o,
  output logic                  lt_o,
  output logic                  hit_o,
  output logic [POS_WIDTH-1:0]  off_o
);

  logic [POS_WIDTH-1:0] key_q, key_d, val_q, val_d, off_q, off_d, col;
  logic                 vld_q, vld_d, hit_q, hit_d, eq, col_le;

  always_comb begin
    lt_o   = vld_q && (key_q < query_i);
    eq     = vld_q && (key_q == query_i);
    col    = cmd_i.rev ? val_q : key_q;
    col_le = vld_q && (col <= query_i);
    hit_d  = cmd_i.probe ? eq : col_le;
    off_d  = '0;
    if (col_le) begin
      off_d = cmd_i.rev ? (key_q - val_q) : (val_q - key_q);
    end

    key_d = key_q;
    val_d = val_q;
    vld_d = vld_q;
    if (cmd_i.clr) begin
      vld_d = 1'b0;
    end else if (cmd_i.upd) begin
      if (eq) begin
        val_d = data_i;
      end
    end else if (cmd_i.ins && !lt_o) begin
      // first cell not below the key takes the new anchor, later cells shift up
      if (prev_lt_i) begin
        key_d = query_i;
        val_d = data_i;
        vld_d = 1'b1;
      end else begin
        key_d = prev_key_i;
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    hit_q <= hit_d;
    off_q <= off_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign vld_o = vld_q;
  assign hit_o = hit_q;
  assign off_o = off_q;

endmodule

// ===== sv/porm_tree.sv =====
// Registered select tree: keeps the offset of the highest-indexed hitting cell.
module porm_tree #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned LEAVES    = 64
) (
  input  logic                  clk_i,
  input  logic                  hit_i [LEAVES],
  input  logic [POS_WIDTH-1:0]  off_i [LEAVES],
  output logic                  hit_o,
  output logic [POS_WIDTH-1:0]  off_o
);

  localparam int unsigned LEVELS = $clog2(LEAVES);
  localparam int unsigned PAD    = 1 << LEVELS;

  logic                 leaf_hit [PAD];
  logic [POS_WIDTH-1:0] leaf_off [PAD];
  logic                 node_hit_q [1:PAD-1];
  logic [POS_WIDTH-1:0] node_off_q [1:PAD-1];

  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < LEAVES) begin : g_real
      assign leaf_hit[i] = hit_i[i];
      assign leaf_off[i] = off_i[i];
    end else begin : g_pad
      assign leaf_hit[i] = 1'b0;
      assign leaf_off[i] = '0;
    end
  end

  for (genvar n = 1; n < PAD; n++) begin : g_node
    logic                 l_hit, r_hit;
    logic [POS_WIDTH-1:0] l_off, r_off;
    if (2 * n >= PAD) begin : g_from_leaf
      assign l_hit = leaf_hit[2*n-PAD];
      assign l_off = leaf_off[2*n-PAD];
      assign r_hit = leaf_hit[2*n+1-PAD];
      assign r_off = leaf_off[2*n+1-PAD];
    end else begin : g_from_node
      assign l_hit = node_hit_q[2*n];
      assign l_off = node_off_q[2*n];
      assign r_hit = node_hit_q[2*n+1];
      assign r_off = node_off_q[2*n+1];
    end
    // higher index wins: later in key order
    always_ff @(posedge clk_i) begin
      node_hit_q[n] <= l_hit | r_hit;
      node_off_q[n] <= r_hit ? r_off : l_off;
    end
  end

  assign hit_o = node_hit_q[1];
  assign off_o = node_off_q[1];

endmodule

// ===== sv/piecewise_offset_remap_table.sv =====
// Top level of the offset remap table: cell row, select tree and sequencer.
// Takes one word at a time. Anchors live in a row of TABLE_DEPTH cells kept
// sorted by key; every cell compares the broadcast query in parallel and a
// registered select tree of L = ceil(log2(TABLE_DEPTH)) levels picks the
// offset. Clear and unused opcodes do no lookup, forward and reverse map do
// one, set does one plus a write step for the insert/shift or overwrite, and
// delta does two (a reverse then a forward lookup). The result register
// frees the input side while a word waits downstream.
module piecewise_offset_remap_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned POS_WIDTH   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic [POS_WIDTH-1:0]  orig_pos_i,
  input  logic [POS_WIDTH-1:0]  new_pos_i,
  input  logic [POS_WIDTH-1:0]  step_len_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [POS_WIDTH-1:0]  result_pos_o,
  output logic                  status_o
);

  localparam int unsigned LEVELS   = $clog2(TABLE_DEPTH);
  localparam int unsigned LAT_LAST = LEVELS + 1;
  localparam int unsigned CNT_W    = $clog2(LAT_LAST + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WRITE, S_DONE} state_e;

  state_e               state_q;
  logic [2:0]           op_q;
  logic [POS_WIDTH-1:0] query_q, data_q, np_q, step_q, pend_res_q, result_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 second_q, exist_q, pend_st_q, status_q, out_valid_q;

  porm_pkg::cell_cmd_t  cmd;
  logic                 cell_lt  [TABLE_DEPTH];
  logic                 cell_vld [TABLE_DEPTH];
  logic [POS_WIDTH-1:0] cell_key [TABLE_DEPTH];
  logic [POS_WIDTH-1:0] cell_val [TABLE_DEPTH];
  logic                 leaf_hit [TABLE_DEPTH];
  logic [POS_WIDTH-1:0] leaf_off [TABLE_DEPTH];
  logic                 root_hit, ready, accept, out_free;
  logic [POS_WIDTH-1:0] root_off;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [POS_WIDTH-1:0] p_key, p_val;
    logic                 p_vld, p_lt;
    if (i == 0) begin : g_head
      assign p_key = '0;
      assign p_val = '0;
      assign p_vld = 1'b0;
      assign p_lt  = 1'b1;
    end else begin : g_link
      assign p_key = cell_key[i-1];
      assign p_val = cell_val[i-1];
      assign p_vld = cell_vld[i-1];
      assign p_lt  = cell_lt[i-1];
    end
    porm_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .query_i    (query_q),
      .data_i     (data_q),
      .prev_key_i (p_key),
      .prev_val_i (p_val),
      .prev_vld_i (p_vld),
      .prev_lt_i  (p_lt),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i]),
      .vld_o      (cell_vld[i]),
      .lt_o       (cell_lt[i]),
      .hit_o      (leaf_hit[i]),
      .off_o      (leaf_off[i])
    );
  end

  porm_tree #(.POS_WIDTH(POS_WIDTH), .LEAVES(TABLE_DEPTH)) u_tree (
    .clk_i (clk_i),
    .hit_i (leaf_hit),
    .off_i (leaf_off),
    .hit_o (root_hit),
    .off_o (root_off)
  );

  assign ready    = (cnt_q == CNT_W'(LAT_LAST));
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd = '0;
    if (state_q == S_EXEC) begin
      cmd.clr   = (op_q == porm_pkg::OP_CLEAR);
      cmd.probe = (op_q == porm_pkg::OP_SET);
      cmd.rev   = (op_q == porm_pkg::OP_REV) || ((op_q == porm_pkg::OP_DELTA) && !second_q);
    end else if (state_q == S_WRITE) begin
      cmd.upd = exist_q;
      cmd.ins = !exist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      query_q     <= '0;
      data_q      <= '0;
      np_q        <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      second_q    <= 1'b0;
      exist_q     <= 1'b0;
      pend_res_q  <= '0;
      pend_st_q   <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
      status_q    <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= opcode_i;
            query_q    <= ((opcode_i == porm_pkg::OP_FWD) || (opcode_i == porm_pkg::OP_SET))
                          ? orig_pos_i : new_pos_i;
            data_q     <= new_pos_i;
            np_q       <= new_pos_i;
            step_q     <= step_len_i;
            cnt_q      <= '0;
            second_q   <= 1'b0;
            pend_res_q <= '0;
            pend_st_q  <= 1'b0;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            porm_pkg::OP_CLEAR: begin
              state_q <= S_DONE;
            end
            porm_pkg::OP_SET: begin
              if (ready) begin
                if (root_hit) begin
                  exist_q <= 1'b1;
                  state_q <= S_WRITE;
                end else if (cell_vld[TABLE_DEPTH-1]) begin
                  pend_st_q <= 1'b1;
                  state_q   <= S_DONE;
                end else begin
                  exist_q <= 1'b0;
                  state_q <= S_WRITE;
                end
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end
            porm_pkg::OP_FWD, porm_pkg::OP_REV: begin
              if (ready) begin
                pend_res_q <= query_q + root_off;
                state_q    <= S_DONE;
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end
            porm_pkg::OP_DELTA: begin
              if (ready) begin
                if (!second_q) begin
                  // step in original space, then rerun as a forward lookup
                  query_q  <= query_q + root_off + step_q;
                  second_q <= 1'b1;
                  cnt_q    <= '0;
                end else begin
                  pend_res_q <= query_q + root_off - np_q;
                  state_q    <= S_DONE;
                end
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_WRITE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result_q <= pend_res_q;
            status_q <= pend_st_q;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign result_pos_o = result_q;
  assign status_o     = status_q;

endmodule

// ===== sv/porm_checker.sv =====
// Port-level checks for the offset remap table, bound to the top level.
`include "piecewise_offset_remap_table_assert.svh"

module porm_checker #(
  parameter int unsigned POS_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [POS_WIDTH-1:0]  result_pos_o,
  input logic                  status_o
);

  // a stalled result word stays offered
  `PORM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // one word in flight: the block is busy right after an accept
  `PORM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a rejected set carries a zero position
  `PORM_ASSERT(a_full_zero, clk_i, rst_ni, !(out_valid_o && status_o) || (result_pos_o == '0))

  // a new result only appears at the end of a busy period
  `PORM_ASSERT(a_result_from_busy, clk_i, rst_ni, !$rose(out_valid_o) || $past(in_stall_o))

endmodule

bind piecewise_offset_remap_table porm_checker #(.POS_WIDTH(POS_WIDTH)) u_porm_checker (.*);

// ===== bench/piecewise_offset_remap_table_tb.sv =====
// Self-checking bench for the offset remap table: random and directed words, in-order result check.
module piecewise_offset_remap_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int unsigned POS_WIDTH      = 32;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PHASE_ITEMS    = 245;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    logic [2:0] opcode;
    pos_t       orig_pos;
    pos_t       new_pos;
    pos_t       step_len;
  } remap_word_t;

  typedef struct packed {
    pos_t result_pos;
    logic status;
  } remap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  pos_t orig_pos_i = '0;
  pos_t new_pos_i = '0;
  pos_t step_len_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pos_t result_pos_o;
  logic status_o;

  piecewise_offset_remap_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .POS_WIDTH  (POS_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .orig_pos_i  (orig_pos_i),
    .new_pos_i   (new_pos_i),
    .step_len_i  (step_len_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_pos_o(result_pos_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  remap_word_t   pending_words[$];
  remap_result_t expected_remaps[$];
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic word_taken = 1'b0;
  logic holdoff_req = 1'b0;
  logic holdoff_seen = 1'b0;
  int   holdoff_left = 0;
  int   stalled_cycles = 0;

  // Shadow of the anchor table, updated in acceptance order.
  pos_t        anchor_key[TABLE_DEPTH];
  pos_t        anchor_val[TABLE_DEPTH];
  int unsigned anchor_count = 0;

  // Stimulus-side view of what was set since the last clear.
  pos_t gen_keys[$];
  pos_t gen_vals[$];
  pos_t gen_last_key;
  pos_t gen_last_val;

  function automatic pos_t orig_to_new(pos_t q);
    int   sel;
    sel = -1;
    for (int i = 0; i < anchor_count; i++) begin
      if (anchor_key[i] <= q) sel = i;
    end
    if (sel < 0) return q;
    return q + anchor_val[sel] - anchor_key[sel];
  endfunction

  function automatic pos_t new_to_orig(pos_t q);
    int   sel;
    sel = -1;
    for (int i = 0; i < anchor_count; i++) begin
      if (anchor_val[i] <= q) sel = i;
    end
    if (sel < 0) return q;
    return q + anchor_key[sel] - anchor_val[sel];
  endfunction

  function automatic logic store_anchor(pos_t key, pos_t val);
    int unsigned slot;
    slot = 0;
    while (slot < anchor_count && anchor_key[slot] < key) slot++;
    if (slot < anchor_count && anchor_key[slot] == key) begin
      anchor_val[slot] = val;
      return 1'b0;
    end
    if (anchor_count >= TABLE_DEPTH) return 1'b1;
    for (int unsigned i = anchor_count; i > slot; i--) begin
      anchor_key[i] = anchor_key[i-1];
      anchor_val[i] = anchor_val[i-1];
    end
    anchor_key[slot] = key;
    anchor_val[slot] = val;
    anchor_count++;
    return 1'b0;
  endfunction

  function automatic remap_result_t predict_remap(remap_word_t w);
    remap_result_t r;
    r = '0;
    case (w.opcode)
      porm_pkg::OP_CLEAR: anchor_count = 0;
      porm_pkg::OP_SET:   r.status = store_anchor(w.orig_pos, w.new_pos);
      porm_pkg::OP_FWD:   r.result_pos = orig_to_new(w.orig_pos);
      porm_pkg::OP_REV:   r.result_pos = new_to_orig(w.new_pos);
      porm_pkg::OP_DELTA:
        r.result_pos = orig_to_new(new_to_orig(w.new_pos) + w.step_len) - w.new_pos;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Sample both handshakes; check the oldest expectation, then predict the new word.
  always @(posedge clk_i) begin
    remap_word_t   w;
    remap_result_t want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_remaps.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual result_pos %h status %b",
                   $time, result_pos_o, status_o);
          mismatch_count++;
        end else begin
          want = expected_remaps.pop_front();
          if (result_pos_o !== want.result_pos) begin
            $display("%0t: result_pos mismatch: expected %h, actual %h",
                     $time, want.result_pos, result_pos_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %b, actual %b",
                     $time, want.status, status_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        w = '{opcode_i, orig_pos_i, new_pos_i, step_len_i};
        expected_remaps.push_back(predict_remap(w));
      end
      word_taken <= in_valid_i && !in_stall_o;
    end
  end

  always @(negedge clk_i) begin
    remap_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // hold the stalled word
    end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      w = pending_words.pop_front();
      opcode_i   <= w.opcode;
      orig_pos_i <= w.orig_pos;
      new_pos_i  <= w.new_pos;
      step_len_i <= w.step_len;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i  <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_words.size() == 0 && !in_valid_i && expected_remaps.size() == 0)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic push_word(logic [2:0] op, pos_t orig, pos_t newp, pos_t step);
    pending_words.push_back('{op, orig, newp, step});
    if (op == porm_pkg::OP_CLEAR) begin
      gen_keys.delete();
      gen_vals.delete();
      gen_last_key = $urandom_range(1000);
      gen_last_val = $urandom_range(1000);
    end else if (op == porm_pkg::OP_SET && gen_keys.size() < 80) begin
      gen_keys.push_back(orig);
      gen_vals.push_back(newp);
    end
  endtask

  // Query close to a known key or value, sometimes anywhere.
  function automatic pos_t near_query(bit on_values);
    int   idx;
    pos_t base;
    if (gen_keys.size() == 0 || $urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return POS_MAX;
        default: return $urandom;
      endcase
    end
    idx  = $urandom_range(gen_keys.size() - 1);
    base = on_values ? gen_vals[idx] : gen_keys[idx];
    return base + pos_t'($urandom_range(2)) - pos_t'(1);
  endfunction

  task automatic push_random_set(bit allow_overwrite);
    pos_t key;
    pos_t val;
    int   pick;
    pick = $urandom_range(99);
    if (allow_overwrite && pick < 30 && gen_keys.size() != 0) begin
      key = gen_keys[$urandom_range(gen_keys.size() - 1)];
    end else if (pick < 70) begin
      gen_last_key = gen_last_key + pos_t'($urandom_range(1 << 24, 1));
      key = gen_last_key;
    end else begin
      key = $urandom;
    end
    if ($urandom_range(4) != 0) begin
      gen_last_val = gen_last_val + pos_t'($urandom_range(1 << 24, 0));
      val = gen_last_val;
    end else begin
      val = $urandom;
    end
    push_word(porm_pkg::OP_SET, key, val, $urandom);
  endtask

  task automatic push_random_op();
    pos_t step;
    int   pick;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0:       step = POS_MAX;
      1:       step = $urandom;
      default: step = $urandom_range(2000);
    endcase
    if (pick < 2)       push_word(porm_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    else if (pick < 25) push_random_set(1'b1);
    else if (pick < 50) push_word(porm_pkg::OP_FWD, near_query(1'b0), $urandom, $urandom);
    else if (pick < 73) push_word(porm_pkg::OP_REV, $urandom, near_query(1'b1), $urandom);
    else if (pick < 97) push_word(porm_pkg::OP_DELTA, $urandom, near_query(1'b1), step);
    else push_word(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                   $urandom, $urandom, $urandom);
  endtask

  // Build a table (now and then past full), then query and modify it.
  task automatic queue_random_words(int count);
    int made;
    int n_sets;
    int n_mix;
    bit filling;
    made = 0;
    while (made < count) begin
      if ($urandom_range(3) != 0) begin
        push_word(porm_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
        made++;
      end
      filling = ($urandom_range(99) < 15);
      n_sets  = filling ? $urandom_range(72, 64) : $urandom_range(8);
      for (int i = 0; i < n_sets; i++) push_random_set(!filling);
      n_mix = $urandom_range(20, 5);
      for (int i = 0; i < n_mix; i++) push_random_op();
      made += n_sets + n_mix;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_remaps.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 88, 0, 32};
    stall_by_phase = '{0, 0, 88, 32};
    gen_last_key = '0;
    gen_last_val = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Empty table, extremes, overwrite, wrap, non-monotonic values, spare opcodes.
    push_word(porm_pkg::OP_CLEAR, '0, '0, '0);
    push_word(porm_pkg::OP_FWD, POS_MAX, '0, '0);
    push_word(porm_pkg::OP_REV, '0, POS_MAX, '0);
    push_word(porm_pkg::OP_DELTA, '0, 32'd500, POS_MAX);
    push_word(porm_pkg::OP_SET, 32'd100, 32'd150, '0);
    push_word(porm_pkg::OP_FWD, 32'd99, '0, '0);
    push_word(porm_pkg::OP_FWD, 32'd100, '0, '0);
    push_word(porm_pkg::OP_SET, 32'd100, 32'd90, POS_MAX);
    push_word(porm_pkg::OP_FWD, 32'd101, '0, '0);
    push_word(porm_pkg::OP_REV, '0, 32'd89, '0);
    push_word(porm_pkg::OP_REV, '0, 32'd90, '0);
    push_word(porm_pkg::OP_SET, '0, POS_MAX, '0);
    push_word(porm_pkg::OP_SET, POS_MAX, '0, '0);
    push_word(porm_pkg::OP_FWD, '0, '0, '0);
    push_word(porm_pkg::OP_FWD, POS_MAX, '0, '0);
    push_word(porm_pkg::OP_SET, 32'd200, 32'd10, '0);
    push_word(porm_pkg::OP_REV, '0, 32'd50, '0);
    push_word(porm_pkg::OP_REV, '0, POS_MAX, '0);
    push_word(porm_pkg::OP_DELTA, '0, 32'd90, 32'd150);
    push_word(porm_pkg::OP_DELTA, POS_MAX, POS_MAX, POS_MAX);
    push_word(OP_SPARE_FIRST, POS_MAX, POS_MAX, POS_MAX);
    push_word(OP_SPARE_LAST, 32'h5555_5555, 32'hAAAA_AAAA, POS_MAX);
    push_word(porm_pkg::OP_FWD, 32'd150, '0, '0);
    wait_drained();

    // Long receiver hold-off with the sender streaming.
    holdoff_req = ~holdoff_req;
    queue_random_words(40);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      queue_random_words(PHASE_ITEMS);
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_remaps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
